/* rtl/afp_pkg.sv */
// Shared types, constants and helper functions of the ASCII hex frame parser.
package afp_pkg;

  localparam int MAX_DATA   = 32;
  localparam int DATA_DEPTH = 64;
  localparam int ADDR_W     = $clog2(DATA_DEPTH);
  localparam int FILL_W     = $clog2(DATA_DEPTH + 1);
  localparam int POS_W      = 6;

  localparam logic [7:0]  SEP_RESET = 8'd44;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  localparam logic [2:0] FIELD_ID   = 3'd0;
  localparam logic [2:0] FIELD_SUB  = 3'd1;
  localparam logic [2:0] FIELD_CMD  = 3'd2;
  localparam logic [2:0] FIELD_LEN  = 3'd3;
  localparam logic [2:0] FIELD_DATA = 3'd4;
  localparam logic [2:0] FIELD_CRC  = 3'd5;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_CRC_ERR   = 2'd1;
  localparam logic [1:0] STAT_MALFORMED = 2'd2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       first;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic             is_header;
    logic [1:0]       status;
    logic [15:0]      frame_id;
    logic [15:0]      sub_id;
    logic [15:0]      opcode;
    logic [15:0]      data_length;
    logic [7:0]       data_value;
    logic [POS_W-1:0] data_position;
    logic             final_res;
  } out_item_t;

  typedef struct packed {
    logic ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic feed;
    logic clr;
    logic rd_en;
    logic rd_sel;
    logic save_c0;
    logic ld_hdr;
    logic ld_data;
    logic k_clr;
    logic k_inc;
  } cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic has_data;
    logic last_k;
  } stat_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok  = 1'b0;
      h.val = 4'd0;
    end
    return h;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/afp_dp.sv */
// Datapath: field accumulators, CRC, data character store and result register.
module afp_dp import afp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  in_item_t    in_item,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  output stat_t       stat,
  output out_item_t   out_item
);

  logic [7:0]        separator;
  logic [2:0]        field_number;
  logic [15:0]       crc_value;
  logic [15:0]       id_accum;
  logic [15:0]       subid_accum;
  logic [15:0]       cmd_accum;
  logic [15:0]       len_accum;
  logic [15:0]       remote_crc_accum;
  logic              field_stopped;
  logic [FILL_W-1:0] data_char_count;
  logic [POS_W-1:0]  k;
  logic [7:0]        mem [DATA_DEPTH];
  logic [7:0]        rdata;
  logic              rvalid;
  logic [7:0]        c0;
  logic              c0_ok;
  out_item_t         out_item_next;

  logic              frame_clr;
  logic [7:0]        b;
  hex_t              h;
  logic              is_sep;
  logic              in_fields;
  logic              mem_we;
  logic [ADDR_W-1:0] rd_addr;
  logic [POS_W-1:0]  cnt;
  hex_t              h0;
  hex_t              h1;
  logic              d0_ok;
  logic              d1_ok;
  logic [7:0]        value;

  assign b         = in_item.frame_byte;
  assign h         = hex_decode(b);
  assign is_sep    = (b == separator);
  assign frame_clr = cmd.clr || (cmd.feed && in_item.first);
  assign in_fields = cmd.feed && !in_item.first && (field_number < FIELD_CRC);
  assign mem_we    = in_fields && !is_sep && (field_number == FIELD_DATA) &&
                     (data_char_count < FILL_W'(DATA_DEPTH));
  assign rd_addr   = ADDR_W'({k, cmd.rd_sel});
  assign cnt       = (len_accum > 16'(MAX_DATA)) ? POS_W'(MAX_DATA) : len_accum[POS_W-1:0];

  assign stat.frame_ok = (field_number == FIELD_CRC) && (remote_crc_accum == crc_value);
  assign stat.has_data = (cnt != '0);
  assign stat.last_k   = ((k + POS_W'(1)) == cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= SEP_RESET;
    end else if (cfg_we) begin
      separator <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || frame_clr) begin
      field_number     <= FIELD_ID;
      crc_value        <= CRC_INIT;
      id_accum         <= '0;
      subid_accum      <= '0;
      cmd_accum        <= '0;
      len_accum        <= '0;
      remote_crc_accum <= '0;
      field_stopped    <= 1'b0;
      data_char_count  <= '0;
    end else if (in_fields) begin
      crc_value <= crc_byte(crc_value, b);
      if (is_sep) begin
        field_number  <= field_number + 3'd1;
        field_stopped <= 1'b0;
      end else begin
        case (field_number)
          FIELD_ID: begin
            if (!field_stopped && h.ok) id_accum <= {id_accum[11:0], h.val};
            field_stopped <= field_stopped || !h.ok;
          end
          FIELD_SUB: begin
            if (!field_stopped && h.ok) subid_accum <= {subid_accum[11:0], h.val};
            field_stopped <= field_stopped || !h.ok;
          end
          FIELD_CMD: begin
            if (!field_stopped && h.ok) cmd_accum <= {cmd_accum[11:0], h.val};
            field_stopped <= field_stopped || !h.ok;
          end
          FIELD_LEN: begin
            if (!field_stopped && h.ok) len_accum <= {len_accum[11:0], h.val};
            field_stopped <= field_stopped || !h.ok;
          end
          default: begin
            if (mem_we) data_char_count <= data_char_count + FILL_W'(1);
          end
        endcase
      end
    end else if (cmd.feed && !in_item.first) begin
      if (!field_stopped && h.ok) remote_crc_accum <= {remote_crc_accum[11:0], h.val};
      field_stopped <= field_stopped || !h.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[data_char_count[ADDR_W-1:0]] <= b;
    end
    if (cmd.rd_en) begin
      rdata  <= mem[rd_addr];
      rvalid <= (FILL_W'(rd_addr) < data_char_count);
    end
    if (cmd.save_c0) begin
      c0    <= rdata;
      c0_ok <= rvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.k_clr) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + POS_W'(1);
    end
  end

  assign h0    = hex_decode(c0);
  assign h1    = hex_decode(rdata);
  assign d0_ok = c0_ok && h0.ok;
  assign d1_ok = rvalid && h1.ok;
  assign value = !d0_ok ? 8'd0 : (!d1_ok ? {4'd0, h0.val} : {h0.val, h1.val});

  always_comb begin
    out_item_next = out_item;
    if (cmd.ld_hdr) begin
      out_item_next           = '0;
      out_item_next.is_header = 1'b1;
      out_item_next.final_res = 1'b1;
      if (field_number != FIELD_CRC) begin
        out_item_next.status = STAT_MALFORMED;
      end else if (remote_crc_accum != crc_value) begin
        out_item_next.status = STAT_CRC_ERR;
      end else begin
        out_item_next.status      = STAT_OK;
        out_item_next.frame_id    = id_accum;
        out_item_next.sub_id      = subid_accum;
        out_item_next.opcode      = cmd_accum;
        out_item_next.data_length = len_accum;
        out_item_next.final_res   = !stat.has_data;
      end
    end else if (cmd.ld_data) begin
      out_item_next               = '0;
      out_item_next.status        = STAT_OK;
      out_item_next.data_value    = value;
      out_item_next.data_position = k;
      out_item_next.final_res     = stat.last_k;
    end
  end

  always_ff @(posedge clk) begin
    out_item <= out_item_next;
  end

  a_field_range: assert property (@(posedge clk) disable iff (rst)
    field_number <= FIELD_CRC) else $error("field number past the CRC field");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    data_char_count <= FILL_W'(DATA_DEPTH)) else $error("store fill count overflow");
  a_crc_frozen: assert property (@(posedge clk) disable iff (rst)
    ((field_number == FIELD_CRC) && !frame_clr) |=> (crc_value == $past(crc_value)))
    else $error("crc changed inside the CRC field");

endmodule

/* rtl/afp_ctrl.sv */
// Controller: input acceptance, result sequencing and output valid.
module afp_ctrl import afp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_last,
  input  logic  out_ready,
  input  stat_t stat,
  output logic  in_ready,
  output logic  out_valid,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN,
    ST_RD0,
    ST_RD1,
    ST_LOAD
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.feed = 1'b1;
          if (in_last) state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.ld_hdr     = 1'b1;
          cmd.k_clr      = 1'b1;
          out_valid_next = 1'b1;
          if (stat.frame_ok && stat.has_data) begin
            state_next = ST_RD0;
          end else begin
            cmd.clr    = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_RD0: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = 1'b1;
        cmd.save_c0 = 1'b1;
        state_next  = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          cmd.ld_data    = 1'b1;
          cmd.k_inc      = 1'b1;
          out_valid_next = 1'b1;
          if (stat.last_k) begin
            cmd.clr    = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_RD0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.ld_hdr || cmd.ld_data) |-> slot_free) else $error("result register overwritten");
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ld_hdr && cmd.ld_data)) else $error("header and data loaded together");
  a_last_fin: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> (state == ST_FIN)) else $error("last item not closed");

endmodule

/* rtl/ascii_hex_frame_parser_crc16_top.sv */
// Top level of the ASCII hex frame parser with CRC-16 check.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   in_item  (frame_byte, first, last)
//  out      output     out_valid / out_ready out_item (header or data byte)
//  cfg      input      cfg_valid / cfg_ready cfg_data (field separator)
//
// After the last item the FIN state loads the header; each data byte then passes
// the RD0, RD1 and LOAD states, set by the two reads through the single read port
// of the character store. Reset sets the separator to a comma and clears the parse;
// the store itself is not cleared, its fill count masks stale entries. A stalled
// output holds the sequencer; input is taken only while it is idle.
module ascii_hex_frame_parser_crc16_top import afp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  afp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_item.last),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  afp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the hex frame parser: framed traffic checked against a local parser.
`timescale 1ns / 100ps

module tb_top;
  import afp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned MAX_PRINTS    = 50;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = SEP_RESET;

  // parser state
  logic [7:0]  sep_reg;
  logic [2:0]  fld_idx;
  logic [15:0] run_crc;
  logic [15:0] id_acc;
  logic [15:0] sub_acc;
  logic [15:0] cmd_acc;
  logic [15:0] len_acc;
  logic [15:0] rx_crc;
  logic        digits_done;
  logic [7:0]  char_mem [DATA_DEPTH];
  int          char_cnt;

  in_item_t    tx_chars[$];
  out_item_t   expected_results[$];
  out_item_t   next_result;
  logic [7:0]  frame_body[$];

  logic        no_idle      = 1'b0;
  logic        hold_armed   = 1'b0;
  logic        hold_off     = 1'b0;
  logic        frame_closed = 1'b1;
  int          send_wait;
  int          recv_wait;
  int unsigned items_queued  = 0;
  int unsigned chars_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned hdr_ok        = 0;
  int unsigned hdr_crc       = 0;
  int unsigned hdr_malformed = 0;
  int unsigned data_bytes    = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  ascii_hex_frame_parser_crc16_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [4:0] hex_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return crc;
  endfunction

  function automatic logic [7:0] char_at(input int idx);
    if (idx < char_cnt) return char_mem[idx];
    return 8'h00;
  endfunction

  task automatic clear_parse();
    fld_idx     = FIELD_ID;
    run_crc     = CRC_INIT;
    id_acc      = '0;
    sub_acc     = '0;
    cmd_acc     = '0;
    len_acc     = '0;
    rx_crc      = '0;
    digits_done = 1'b0;
    char_cnt    = 0;
    foreach (char_mem[i]) char_mem[i] = 8'h00;
  endtask

  task automatic accum_hex(inout logic [15:0] acc, input logic [7:0] c);
    logic [4:0] h;
    h = hex_of(c);
    if (digits_done) return;
    if (!h[4]) begin
      digits_done = 1'b1;
    end else begin
      acc = {acc[11:0], h[3:0]};
    end
  endtask

  task automatic parse_char(input in_item_t it);
    out_item_t  r;
    int         n_bytes;
    logic [4:0] hi;
    logic [4:0] lo;
    n_bytes = 0;
    if (it.first) begin
      clear_parse();
    end else if (fld_idx < FIELD_CRC) begin
      run_crc = crc_step(run_crc, it.frame_byte);
      if (it.frame_byte == sep_reg) begin
        fld_idx     = fld_idx + 3'd1;
        digits_done = 1'b0;
      end else begin
        case (fld_idx)
          FIELD_ID:  accum_hex(id_acc, it.frame_byte);
          FIELD_SUB: accum_hex(sub_acc, it.frame_byte);
          FIELD_CMD: accum_hex(cmd_acc, it.frame_byte);
          FIELD_LEN: accum_hex(len_acc, it.frame_byte);
          default: begin
            if (char_cnt < DATA_DEPTH) begin
              char_mem[char_cnt] = it.frame_byte;
              char_cnt++;
            end
          end
        endcase
      end
    end else begin
      accum_hex(rx_crc, it.frame_byte);
    end
    if (!it.last) return;

    r           = '0;
    r.is_header = 1'b1;
    r.final_res = 1'b1;
    if (fld_idx < FIELD_CRC) begin
      r.status = STAT_MALFORMED;
    end else if (rx_crc != run_crc) begin
      r.status = STAT_CRC_ERR;
    end else begin
      n_bytes       = (len_acc > MAX_DATA) ? MAX_DATA : int'(len_acc);
      r.status      = STAT_OK;
      r.frame_id    = id_acc;
      r.sub_id      = sub_acc;
      r.opcode      = cmd_acc;
      r.data_length = len_acc;
      r.final_res   = (n_bytes == 0);
    end
    expected_results.push_back(r);
    for (int k = 0; k < n_bytes; k++) begin
      hi = hex_of(char_at(2 * k));
      lo = hex_of(char_at(2 * k + 1));
      r  = '0;
      if (!hi[4]) begin
        r.data_value = 8'h00;
      end else if (!lo[4]) begin
        r.data_value = {4'h0, hi[3:0]};
      end else begin
        r.data_value = {hi[3:0], lo[3:0]};
      end
      r.data_position = POS_W'(k);
      r.final_res     = (k == n_bytes - 1);
      expected_results.push_back(r);
    end
    clear_parse();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'((($urandom_range(0, 1) != 0) ? "A" : "a") + n - 4'd10);
  endfunction

  function automatic logic [7:0] rand_nonhex(input logic allow_sep);
    logic [7:0] c;
    c = 8'($urandom);
    while (hex_of(c) != 5'd0 || (!allow_sep && c == sep_reg)) c = 8'($urandom);
    return c;
  endfunction

  function automatic logic [15:0] body_crc();
    logic [15:0] sum;
    sum = CRC_INIT;
    foreach (frame_body[i]) sum = crc_step(sum, frame_body[i]);
    return sum;
  endfunction

  task automatic append_hex(input logic [23:0] v, input int nd);
    for (int i = nd - 1; i >= 0; i--) frame_body.push_back(hex_char(v[4 * i +: 4]));
  endtask

  task automatic load_text(input string s);
    frame_body.delete();
    for (int i = 0; i < s.len(); i++) frame_body.push_back(s[i]);
  endtask

  task automatic push_item(input logic [7:0] c, input logic f, input logic l);
    in_item_t it;
    it.frame_byte = c;
    it.first      = f;
    it.last       = l;
    tx_chars.push_back(it);
    items_queued++;
  endtask

  task automatic send_body(input logic with_first);
    if (with_first) push_item(($urandom_range(0, 1) != 0) ? 8'h3A : 8'($urandom), 1'b1, 1'b0);
    foreach (frame_body[i]) push_item(frame_body[i], 1'b0, (i == frame_body.size() - 1));
  endtask

  task automatic build_body(input logic bad_crc);
    logic [23:0] v;
    logic [15:0] len_v;
    logic [15:0] sum;
    int          nd;
    int          pick;
    int          n_chars;
    frame_body.delete();
    len_v = '0;
    for (int f = 0; f < 4; f++) begin
      pick = $urandom_range(0, 9);
      nd   = $urandom_range(1, 6);
      v    = 24'($urandom);
      if (f == 3) begin
        if (pick == 0) begin
          nd = $urandom_range(4, 6);
        end else begin
          v  = (pick == 1) ? 24'($urandom_range(9, 40)) : 24'($urandom_range(0, 8));
          nd = $urandom_range(2, 4);
        end
        len_v = v[15:0];
      end else if (pick == 0) begin
        v = '0;
      end else if (pick == 1) begin
        v = '1;
      end
      append_hex(v, nd);
      if ($urandom_range(0, 9) == 0) frame_body.push_back(rand_nonhex(1'b0));
      frame_body.push_back(sep_reg);
    end
    case ($urandom_range(0, 9))
      0:       n_chars = $urandom_range(65, 72);
      1:       n_chars = $urandom_range(0, 64);
      default: n_chars = 2 * ((len_v > MAX_DATA) ? MAX_DATA : int'(len_v));
    endcase
    repeat (n_chars) begin
      if ($urandom_range(0, 9) == 0) begin
        frame_body.push_back(rand_nonhex(1'b0));
      end else begin
        frame_body.push_back(hex_char(4'($urandom)));
      end
    end
    frame_body.push_back(sep_reg);
    sum = body_crc();
    if (bad_crc) sum = sum ^ (16'd1 << $urandom_range(0, 15));
    append_hex({8'h00, sum}, 4);
    case ($urandom_range(0, 3))
      0: frame_body.push_back(rand_nonhex(1'b1));
      1: begin
        frame_body.push_back(rand_nonhex(1'b1));
        frame_body.push_back(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic queue_random_frame();
    int   kind;
    int   cut;
    logic with_first;
    logic l;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      build_body(kind < 14);
      if (kind >= 70) begin
        cut        = $urandom_range(0, frame_body.size() - 2);
        frame_body = frame_body[0:cut];
      end
      with_first = !frame_closed || ($urandom_range(0, 6) != 0);
      if (with_first && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) push_item(8'($urandom), 1'b0, 1'b0);
      end
      send_body(with_first);
      frame_closed = 1'b1;
    end else begin
      l = 1'b0;
      repeat ($urandom_range(1, 6)) begin
        l = ($urandom_range(0, 3) == 0);
        push_item(8'($urandom), ($urandom_range(0, 3) == 0), l);
      end
      frame_closed = l;
    end
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned start;
    start = items_queued;
    while (items_queued - start < n_items) queue_random_frame();
  endtask

  task automatic drain();
    @(negedge clk);
    while (tx_chars.size() != 0 || in_valid || expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_separator(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sep_reg = v;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTS) begin
      $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
    end
  endtask

  // drive frame characters
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_char(in_item);
        chars_taken++;
        send_wait = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (tx_chars.size() != 0) begin
          in_item  <= tx_chars.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // check results
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending", out_item.is_header, 16'd0);
        end else begin
          next_result = expected_results.pop_front();
          if (out_item.is_header !== next_result.is_header)
            report_mismatch("is_header", out_item.is_header, next_result.is_header);
          if (out_item.status !== next_result.status)
            report_mismatch("status", out_item.status, next_result.status);
          if (out_item.frame_id !== next_result.frame_id)
            report_mismatch("frame_id", out_item.frame_id, next_result.frame_id);
          if (out_item.sub_id !== next_result.sub_id)
            report_mismatch("sub_id", out_item.sub_id, next_result.sub_id);
          if (out_item.opcode !== next_result.opcode)
            report_mismatch("opcode", out_item.opcode, next_result.opcode);
          if (out_item.data_length !== next_result.data_length)
            report_mismatch("data_length", out_item.data_length, next_result.data_length);
          if (out_item.data_value !== next_result.data_value)
            report_mismatch("data_value", out_item.data_value, next_result.data_value);
          if (out_item.data_position !== next_result.data_position)
            report_mismatch("data_position", out_item.data_position,
                            next_result.data_position);
          if (out_item.final_res !== next_result.final_res)
            report_mismatch("final_res", out_item.final_res, next_result.final_res);
          if (!next_result.is_header) begin
            data_bytes++;
          end else begin
            case (next_result.status)
              STAT_OK:      hdr_ok++;
              STAT_CRC_ERR: hdr_crc++;
              default:      hdr_malformed++;
            endcase
          end
        end
        recv_wait = no_idle ? 0 : $urandom_range(0, 8);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_ready <= !hold_off && (recv_wait == 0);
    end
  end

  // hold off the receiver for a long stretch while input keeps coming
  initial begin
    wait (hold_armed);
    repeat (30) @(posedge clk);
    hold_off <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    sep_reg = SEP_RESET;
    clear_parse();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hFF, 1'b1, 1'b1);
    load_text("1,2,3,1,7,");
    append_hex({8'h00, body_crc()}, 4);
    send_body(1'b1);
    load_text(",,,,,0");
    send_body(1'b0);
    run_random(70);
    drain();

    write_separator(8'hFF);
    no_idle = 1'b1;
    @(negedge clk);
    run_random(70);
    drain();

    write_separator(8'h00);
    no_idle = 1'b0;
    @(negedge clk);
    hold_armed = 1'b1;
    run_random(70);
    drain();

    write_separator(8'h3B);
    @(negedge clk);
    run_random(70);
    drain();

    $display("covered %0d frame characters under four separators, %0d results checked",
             chars_taken, results_seen);
    $display("headers: %0d ok, %0d crc error, %0d malformed; data bytes: %0d",
             hdr_ok, hdr_crc, hdr_malformed, data_bytes);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
